[design/gfa_pkg.sv]
// gfa_pkg: shared constants, types and helpers for the grid first-fit allocator
// no dependencies; used by the interfaces, the fit finder and the top level

package gfa_pkg;

    // grid geometry
    localparam int MAX_COLS  = 16;
    localparam int MAX_ROWS  = 16;
    localparam int NUM_GRIDS = 3;
    localparam int DEPTH     = NUM_GRIDS * MAX_COLS;
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int CNT_W     = 5;
    localparam int GRID_W    = 2;
    localparam int ADDR_W    = GRID_W + COL_W;

    typedef logic [MAX_ROWS-1:0] col_word_t;
    typedef logic [CNT_W-1:0]    cnt_t;

    // commands
    localparam logic CMD_PLACE = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_PLACED = 2'd0;
    localparam logic [1:0] ST_NOROOM = 2'd1;
    localparam logic [1:0] ST_FREED  = 2'd2;

    // configuration register indexes and reset values
    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;
    localparam cnt_t GRID_WIDTH_RST  = 5'd10;
    localparam cnt_t GRID_HEIGHT_RST = 5'd6;

    // fit finder answer
    typedef struct packed {
        logic             found;
        logic [ROW_W-1:0] row;
    } fit_t;

    // mask of the n low bits, n up to MAX_ROWS
    function automatic col_word_t low_mask(input cnt_t n);
        logic [MAX_ROWS:0] t;
        t = ({{MAX_ROWS{1'b0}}, 1'b1} << n) - {{MAX_ROWS{1'b0}}, 1'b1};
        return t[MAX_ROWS-1:0];
    endfunction

endpackage

[design/gfa_if.sv]
// gfa_req_if and gfa_rsp_if: valid/ready channels of the allocator
// depends on gfa_pkg

interface gfa_req_if;
    logic                      valid;
    logic                      ready;
    logic                      command;
    logic [gfa_pkg::GRID_W-1:0] grid_select;
    gfa_pkg::cnt_t             rect_width;
    gfa_pkg::cnt_t             rect_height;
    logic [gfa_pkg::COL_W-1:0] free_x;
    logic [gfa_pkg::ROW_W-1:0] free_y;

    modport source (output valid, command, grid_select, rect_width, rect_height,
                    free_x, free_y, input ready);
    modport sink   (input valid, command, grid_select, rect_width, rect_height,
                    free_x, free_y, output ready);
endinterface

interface gfa_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                status;
    logic [gfa_pkg::COL_W-1:0] place_x;
    logic [gfa_pkg::ROW_W-1:0] place_y;

    modport source (output valid, status, place_x, place_y, input ready);
    modport sink   (input valid, status, place_x, place_y, output ready);
endinterface

[design/gfa_fit_find.sv]
// gfa_fit_find: finds the first row where a rectangle fits, given per-row
// free-column run lengths; depends on gfa_pkg

module gfa_fit_find
(
    input  gfa_pkg::cnt_t run [gfa_pkg::MAX_ROWS],
    input  gfa_pkg::cnt_t rect_w,
    input  gfa_pkg::cnt_t rect_h,
    input  gfa_pkg::cnt_t rows,
    output gfa_pkg::fit_t fit
);

    gfa_pkg::col_word_t ok;
    gfa_pkg::col_word_t hmask;

    // a row is usable when its free run covers the rectangle width
    always_comb
    begin
        for (int y = 0; y < gfa_pkg::MAX_ROWS; y++)
        begin
            ok[y] = (run[y] >= rect_w);
        end
        hmask = gfa_pkg::low_mask(rect_h);
    end

    // lowest row with a full window of usable rows inside the grid
    always_comb
    begin
        gfa_pkg::col_word_t win;
        win = '0;
        fit = '0;
        for (int y = gfa_pkg::MAX_ROWS - 1; y >= 0; y--)
        begin
            win = ok >> y;
            if (((win & hmask) == hmask) &&
                ((gfa_pkg::CNT_W'(y) + rect_h) <= rows))
            begin
                fit.found = 1'b1;
                fit.row   = gfa_pkg::ROW_W'(y);
            end
        end
    end

endmodule

[design/grid_rect_first_fit_allocator_core.sv]
// grid_rect_first_fit_allocator_core: first-fit rectangle allocator top level
// place: the scan reads one column per cycle, then the fill does one
// read-modify-write per covered column; free does only the fill
// throughput: one request at a time; the occupancy memory port sets the pace
// reset: all cells free at once through per-entry valid flags, grid 10 x 6
// depends on gfa_pkg, gfa_if and gfa_fit_find

module grid_rect_first_fit_allocator_core
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic            cfg_index,
    input  gfa_pkg::cnt_t   cfg_wdata,
    gfa_req_if.sink         req,
    gfa_rsp_if.source       rsp
);

    typedef enum logic [3:0]
    {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_FILL   = 4'b0100,
        S_RESULT = 4'b1000
    } state_t;

    localparam int MR = gfa_pkg::MAX_ROWS;

    state_t state_reg, state_next;

    // configuration
    gfa_pkg::cnt_t grid_width_reg, grid_height_reg;

    // request context
    logic                       cmd_reg, cmd_next;
    logic [gfa_pkg::GRID_W-1:0] grid_reg, grid_next;
    gfa_pkg::cnt_t              w_reg, w_next, h_reg, h_next;
    gfa_pkg::cnt_t              cols_reg, cols_next, rows_reg, rows_next;

    // scan pipeline
    gfa_pkg::cnt_t              scan_col_reg, scan_col_next;
    logic                       s1_vld_reg, s1_vld_next, s2_vld_reg, s2_vld_next;
    logic [gfa_pkg::COL_W-1:0]  s1_col_reg, s1_col_next, s2_col_reg, s2_col_next;
    gfa_pkg::cnt_t              run_reg [MR];
    gfa_pkg::cnt_t              run_next [MR];
    gfa_pkg::fit_t              fit;

    // fill pipeline
    gfa_pkg::cnt_t              fill_col_reg, fill_col_next, fill_end_reg, fill_end_next;
    gfa_pkg::col_word_t         fill_mask_reg, fill_mask_next;
    logic                       fs1_vld_reg, fs1_vld_next;
    logic [gfa_pkg::COL_W-1:0]  fs1_col_reg, fs1_col_next;

    // result
    logic [1:0]                 res_status_reg, res_status_next;
    logic [gfa_pkg::COL_W-1:0]  res_x_reg, res_x_next;
    logic [gfa_pkg::ROW_W-1:0]  res_y_reg, res_y_next;
    logic                       rsp_vld_reg, rsp_vld_next;
    logic [1:0]                 rsp_status_reg, rsp_status_next;
    logic [gfa_pkg::COL_W-1:0]  rsp_x_reg, rsp_x_next;
    logic [gfa_pkg::ROW_W-1:0]  rsp_y_reg, rsp_y_next;

    // occupancy memory
    gfa_pkg::col_word_t         mem [gfa_pkg::DEPTH];
    logic                       valid_reg [gfa_pkg::DEPTH];
    gfa_pkg::col_word_t         rd_data_reg;
    logic                       rd_ok_reg;
    gfa_pkg::col_word_t         col_data;
    logic                       rd_en, wr_en;
    logic [gfa_pkg::ADDR_W-1:0] rd_addr, wr_addr;
    gfa_pkg::col_word_t         wr_data;

    // request decode
    logic                       req_fire;
    gfa_pkg::cnt_t              cols_eff, rows_eff, xe, ye;
    logic [gfa_pkg::CNT_W:0]    xe_sum, ye_sum;
    logic                       place_bad, free_ok;

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;

    assign rsp.valid   = rsp_vld_reg;
    assign rsp.status  = rsp_status_reg;
    assign rsp.place_x = rsp_x_reg;
    assign rsp.place_y = rsp_y_reg;

    // a never-written entry reads as free
    assign col_data = rd_ok_reg ? rd_data_reg : '0;

    // clamp grid size and decode request limits
    always_comb
    begin
        cols_eff = (grid_width_reg > gfa_pkg::CNT_W'(gfa_pkg::MAX_COLS)) ?
                   gfa_pkg::CNT_W'(gfa_pkg::MAX_COLS) : grid_width_reg;
        rows_eff = (grid_height_reg > gfa_pkg::CNT_W'(gfa_pkg::MAX_ROWS)) ?
                   gfa_pkg::CNT_W'(gfa_pkg::MAX_ROWS) : grid_height_reg;
        place_bad = (req.grid_select >= gfa_pkg::GRID_W'(gfa_pkg::NUM_GRIDS)) ||
                    (req.rect_width == '0) || (req.rect_height == '0) ||
                    (req.rect_width > cols_eff) || (req.rect_height > rows_eff);
        free_ok = (req.grid_select < gfa_pkg::GRID_W'(gfa_pkg::NUM_GRIDS)) &&
                  ({1'b0, req.free_x} < cols_eff) && ({1'b0, req.free_y} < rows_eff) &&
                  (req.rect_width != '0) && (req.rect_height != '0);
        xe_sum = {2'b00, req.free_x} + {1'b0, req.rect_width};
        ye_sum = {2'b00, req.free_y} + {1'b0, req.rect_height};
        xe = (xe_sum > {1'b0, cols_eff}) ? cols_eff : xe_sum[gfa_pkg::CNT_W-1:0];
        ye = (ye_sum > {1'b0, rows_eff}) ? rows_eff : ye_sum[gfa_pkg::CNT_W-1:0];
    end

    gfa_fit_find u_fit
    (
        .run    (run_reg),
        .rect_w (w_reg),
        .rect_h (h_reg),
        .rows   (rows_reg),
        .fit    (fit)
    );

    // control and datapath next state
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        grid_next       = grid_reg;
        w_next          = w_reg;
        h_next          = h_reg;
        cols_next       = cols_reg;
        rows_next       = rows_reg;
        scan_col_next   = scan_col_reg;
        s1_vld_next     = 1'b0;
        s1_col_next     = scan_col_reg[gfa_pkg::COL_W-1:0];
        s2_vld_next     = 1'b0;
        s2_col_next     = s1_col_reg;
        run_next        = run_reg;
        fill_col_next   = fill_col_reg;
        fill_end_next   = fill_end_reg;
        fill_mask_next  = fill_mask_reg;
        fs1_vld_next    = 1'b0;
        fs1_col_next    = fill_col_reg[gfa_pkg::COL_W-1:0];
        res_status_next = res_status_reg;
        res_x_next      = res_x_reg;
        res_y_next      = res_y_reg;
        rsp_vld_next    = rsp_vld_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_x_next      = rsp_x_reg;
        rsp_y_next      = rsp_y_reg;
        rd_en           = 1'b0;
        rd_addr         = {grid_reg, scan_col_reg[gfa_pkg::COL_W-1:0]};
        wr_en           = 1'b0;
        wr_addr         = {grid_reg, fs1_col_reg};
        wr_data         = (cmd_reg == gfa_pkg::CMD_PLACE) ? (col_data | fill_mask_reg) :
                                                           (col_data & ~fill_mask_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    cmd_next      = req.command;
                    grid_next     = req.grid_select;
                    w_next        = req.rect_width;
                    h_next        = req.rect_height;
                    cols_next     = cols_eff;
                    rows_next     = rows_eff;
                    scan_col_next = '0;
                    res_x_next    = '0;
                    res_y_next    = '0;
                    for (int y = 0; y < MR; y++)
                    begin
                        run_next[y] = '0;
                    end
                    if (req.command == gfa_pkg::CMD_PLACE)
                    begin
                        res_status_next = gfa_pkg::ST_NOROOM;
                        state_next      = place_bad ? S_RESULT : S_SCAN;
                    end
                    else
                    begin
                        res_status_next = gfa_pkg::ST_FREED;
                        fill_col_next   = {1'b0, req.free_x};
                        fill_end_next   = xe;
                        fill_mask_next  = gfa_pkg::low_mask(ye) &
                                          ~gfa_pkg::low_mask({1'b0, req.free_y});
                        state_next      = free_ok ? S_FILL : S_RESULT;
                    end
                end
            end

            S_SCAN:
            begin
                // issue one column read per cycle
                if (scan_col_reg < cols_reg)
                begin
                    rd_en         = 1'b1;
                    scan_col_next = scan_col_reg + 5'd1;
                end
                s1_vld_next = rd_en;

                // extend per-row free runs with the column just read
                if (s1_vld_reg)
                begin
                    for (int y = 0; y < MR; y++)
                    begin
                        run_next[y] = col_data[y] ? '0 : run_reg[y] + 5'd1;
                    end
                    s2_vld_next = 1'b1;
                end

                // runs now end at column s2; check start column s2 - w + 1
                if (s2_vld_reg && (({1'b0, s2_col_reg} + 5'd1) >= w_reg))
                begin
                    if (fit.found)
                    begin
                        fill_col_next   = {1'b0, s2_col_reg} + 5'd1 - w_reg;
                        fill_end_next   = {1'b0, s2_col_reg} + 5'd1;
                        fill_mask_next  = gfa_pkg::low_mask(h_reg) << fit.row;
                        res_status_next = gfa_pkg::ST_PLACED;
                        res_x_next      = s2_col_reg + gfa_pkg::COL_W'(1) -
                                          w_reg[gfa_pkg::COL_W-1:0];
                        res_y_next      = fit.row;
                        s1_vld_next     = 1'b0;
                        s2_vld_next     = 1'b0;
                        state_next      = S_FILL;
                    end
                    else if (({1'b0, s2_col_reg} + 5'd1) == cols_reg)
                    begin
                        s1_vld_next = 1'b0;
                        s2_vld_next = 1'b0;
                        state_next  = S_RESULT;
                    end
                end
            end

            S_FILL:
            begin
                // read column, write it back modified in the next cycle
                rd_addr = {grid_reg, fill_col_reg[gfa_pkg::COL_W-1:0]};
                if (fill_col_reg < fill_end_reg)
                begin
                    rd_en         = 1'b1;
                    fill_col_next = fill_col_reg + 5'd1;
                end
                fs1_vld_next = rd_en;
                wr_en        = fs1_vld_reg;
                if (!rd_en && !fs1_vld_reg)
                begin
                    state_next = S_RESULT;
                end
            end

            S_RESULT:
            begin
                if (!rsp_vld_reg || rsp.ready)
                begin
                    rsp_vld_next    = 1'b1;
                    rsp_status_next = res_status_reg;
                    rsp_x_next      = res_x_reg;
                    rsp_y_next      = res_y_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            fs1_vld_reg <= 1'b0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            s1_vld_reg  <= s1_vld_next;
            s2_vld_reg  <= s2_vld_next;
            fs1_vld_reg <= fs1_vld_next;
            rsp_vld_reg <= rsp_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        grid_reg       <= grid_next;
        w_reg          <= w_next;
        h_reg          <= h_next;
        cols_reg       <= cols_next;
        rows_reg       <= rows_next;
        scan_col_reg   <= scan_col_next;
        s1_col_reg     <= s1_col_next;
        s2_col_reg     <= s2_col_next;
        run_reg        <= run_next;
        fill_col_reg   <= fill_col_next;
        fill_end_reg   <= fill_end_next;
        fill_mask_reg  <= fill_mask_next;
        fs1_col_reg    <= fs1_col_next;
        res_status_reg <= res_status_next;
        res_x_reg      <= res_x_next;
        res_y_reg      <= res_y_next;
        rsp_status_reg <= rsp_status_next;
        rsp_x_reg      <= rsp_x_next;
        rsp_y_reg      <= rsp_y_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= gfa_pkg::GRID_WIDTH_RST;
            grid_height_reg <= gfa_pkg::GRID_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gfa_pkg::REG_GRID_WIDTH:  grid_width_reg  <= cfg_wdata;
                gfa_pkg::REG_GRID_HEIGHT: grid_height_reg <= cfg_wdata;
                default:                  grid_width_reg  <= grid_width_reg;
            endcase
        end
    end

    // occupancy memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // per-entry valid flags stand in for clearing the memory
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < gfa_pkg::DEPTH; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_ok_reg <= valid_reg[rd_addr];
            end
        end
    end

    // memory is only written while a fill is in progress
    a_write_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_FILL))
        else $error("occupancy write outside fill");

    // an accepted request blocks the next one
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> !req.ready)
        else $error("request accepted while busy");

    // a placed rectangle lies inside the grid in use
    a_place_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_RESULT) && (res_status_reg == gfa_pkg::ST_PLACED)) |->
        ((({1'b0, res_x_reg} + w_reg) <= cols_reg) &&
         (({1'b0, res_y_reg} + h_reg) <= rows_reg)))
        else $error("placement outside grid");

endmodule
